FILE: rtl/core/indexed_list_engine_defines.svh
// Assertion macros shared by the indexed list engine RTL.
`ifndef INDEXED_LIST_ENGINE_DEFINES_SVH
`define INDEXED_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define ILE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ILE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/ile_pkg.sv
// Package with command codes, status codes, sequencer states and payload structs.
package ile_pkg;

  typedef enum logic [3:0] {
    CMD_INS_HEAD = 4'd0,
    CMD_INS_TAIL = 4'd1,
    CMD_INS_AT   = 4'd2,
    CMD_RM_HEAD  = 4'd3,
    CMD_RM_TAIL  = 4'd4,
    CMD_RM_AT    = 4'd5,
    CMD_READ     = 4'd6,
    CMD_REPLACE  = 4'd7,
    CMD_SEARCH   = 4'd8,
    CMD_COMPARE  = 4'd9,
    CMD_SWAP     = 4'd10,
    CMD_CLEAR    = 4'd11
  } ile_cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } ile_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_MOVE,
    S_SCAN,
    S_FETCH,
    S_SWAP_A,
    S_SWAP_B,
    S_SWAP_C,
    S_RESP
  } ile_state_t;

  typedef struct packed {
    logic [3:0]         command;
    logic signed [31:0] value;
    logic [4:0]         position;
    logic [4:0]         other_position;
  } ile_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic               found;
    logic [4:0]         count;
  } ile_rsp_t;

endpackage

FILE: rtl/core/ile_store.sv
// Entry store: one write port, one read port with registered read data.
module ile_store #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write the addressed entry and register the read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/core/indexed_list_engine.sv
// Top level of the indexed list engine: command decode, shift/scan sequencer, result stage.
// Usage:
//   Commands arrive on cmd_valid/cmd_ready/cmd_item; one result per command leaves on
//   res_valid/res_ready/res_item with status, read data, found flag and the count.
//   The block takes one command at a time: cmd_ready is high only while the sequencer
//   is idle. Entries live in a single-port-write, single-port-read store, and one read
//   and one write are done per cycle, so the store ports set the cost of each command.
//   Insert and remove shift the entries behind the position one slot through the store;
//   search reads each entry in turn; read and compare fetch one entry; swap reads both
//   entries and writes both unless the indices are equal. Replace, clear, rejected commands,
//   swaps with equal indices and searches of an empty list go from decode to the result state.
//   A new command can be accepted in the cycle after the result is loaded.
//   The result sits in an output register; the next command is accepted while it waits.
//   If the receiver stalls with a result still pending, the next command finishes its
//   work and holds in the result state until the output register frees up.
//   Reset (rst, synchronous) empties the list and drops any pending result; store
//   contents are left as they are and are never read below a zero count.
`include "indexed_list_engine_defines.svh"

module indexed_list_engine #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  ile_pkg::ile_req_t cmd_item,
  output logic              res_valid,
  input  logic              res_ready,
  output ile_pkg::ile_rsp_t res_item
);

  import ile_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int PW    = (CNT_W > 5) ? CNT_W : 5;

  ile_state_t            state, state_next;
  logic [CNT_W-1:0]      cnt, cnt_next;
  ile_req_t              cur, cur_next;
  logic [DATA_WIDTH-1:0] vdat, vdat_next;
  logic [IDX_W-1:0]      ptr, ptr_next;
  logic [CNT_W-1:0]      left, left_next;
  logic                  dir_up, dir_up_next;
  logic [IDX_W-1:0]      place, place_next;
  logic                  pipe_vld, pipe_vld_next;
  logic [IDX_W-1:0]      pipe_dst, pipe_dst_next;
  logic [DATA_WIDTH-1:0] tmp, tmp_next;
  ile_status_t           res_status, res_status_next;
  logic [31:0]           res_read, res_read_next;
  logic                  res_found, res_found_next;
  logic                  res_valid_next;
  ile_rsp_t              res_item_next;

  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [IDX_W-1:0]      rd_addr;
  logic [DATA_WIDTH-1:0] rd_data;
  logic                  eq;
  logic [63:0]           vsx;

  ile_store #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_WIDTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Shared equality unit for search and compare
  assign eq = (rd_data == vdat);

  // Sign-extend the incoming value, then keep the stored width
  assign vsx = {{32{cmd_item.value[31]}}, cmd_item.value};

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      pipe_vld  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      pipe_vld  <= pipe_vld_next;
      res_valid <= res_valid_next;
    end
  end

  // Payload and datapath registers
  always_ff @(posedge clk) begin
    cur        <= cur_next;
    vdat       <= vdat_next;
    ptr        <= ptr_next;
    left       <= left_next;
    dir_up     <= dir_up_next;
    place      <= place_next;
    pipe_dst   <= pipe_dst_next;
    tmp        <= tmp_next;
    res_status <= res_status_next;
    res_read   <= res_read_next;
    res_found  <= res_found_next;
    res_item   <= res_item_next;
  end

  // Sequencer: next state, store ports and datapath updates
  always_comb begin
    logic [PW-1:0]    pos_x;
    logic [PW-1:0]    oth_x;
    logic [PW-1:0]    cnt_x;
    logic [IDX_W-1:0] pos_i;
    logic [IDX_W-1:0] oth_i;
    logic [CNT_W-1:0] at_c;
    logic [63:0]      rd64;

    pos_x = PW'(cur.position);
    oth_x = PW'(cur.other_position);
    cnt_x = PW'(cnt);
    pos_i = IDX_W'(pos_x);
    oth_i = IDX_W'(oth_x);
    at_c  = '0;
    rd64  = 64'(rd_data);

    state_next      = state;
    cnt_next        = cnt;
    cur_next        = cur;
    vdat_next       = vdat;
    ptr_next        = ptr;
    left_next       = left;
    dir_up_next     = dir_up;
    place_next      = place;
    pipe_vld_next   = 1'b0;
    pipe_dst_next   = pipe_dst;
    tmp_next        = tmp;
    res_status_next = res_status;
    res_read_next   = res_read;
    res_found_next  = res_found;
    res_item_next   = res_item;
    res_valid_next  = res_valid && !res_ready;

    wr_en     = 1'b0;
    wr_addr   = pipe_dst;
    wr_data   = rd_data;
    rd_addr   = ptr;
    cmd_ready = (state == S_IDLE);

    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          cur_next   = cmd_item;
          vdat_next  = vsx[DATA_WIDTH-1:0];
          state_next = S_DECODE;
        end
      end

      S_DECODE: begin
        res_status_next = ST_OK;
        res_read_next   = '0;
        res_found_next  = 1'b0;
        state_next      = S_RESP;
        case (cur.command)
          CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_AT: begin
            if (cnt == CNT_W'(CAPACITY)) begin
              res_status_next = ST_FULL;
            end else if (cur.command == CMD_INS_AT && pos_x > cnt_x) begin
              res_status_next = ST_RANGE;
            end else begin
              if (cur.command == CMD_INS_HEAD) begin
                at_c = '0;
              end else if (cur.command == CMD_INS_TAIL) begin
                at_c = cnt;
              end else begin
                at_c = CNT_W'(pos_x);
              end
              place_next  = IDX_W'(at_c);
              left_next   = cnt - at_c;
              ptr_next    = IDX_W'(cnt - 1'b1);
              dir_up_next = 1'b1;
              state_next  = S_MOVE;
            end
          end
          CMD_RM_HEAD, CMD_RM_TAIL, CMD_RM_AT: begin
            if (cnt == '0) begin
              res_status_next = ST_EMPTY;
            end else if (cur.command == CMD_RM_AT && pos_x >= cnt_x) begin
              res_status_next = ST_RANGE;
            end else begin
              if (cur.command == CMD_RM_HEAD) begin
                at_c = '0;
              end else if (cur.command == CMD_RM_TAIL) begin
                at_c = cnt - 1'b1;
              end else begin
                at_c = CNT_W'(pos_x);
              end
              left_next   = cnt - 1'b1 - at_c;
              ptr_next    = IDX_W'(at_c + 1'b1);
              dir_up_next = 1'b0;
              state_next  = S_MOVE;
            end
          end
          CMD_READ, CMD_REPLACE, CMD_COMPARE, CMD_SWAP: begin
            if (cnt == '0) begin
              res_status_next = ST_EMPTY;
            end else if (pos_x >= cnt_x ||
                         (cur.command == CMD_SWAP && oth_x >= cnt_x)) begin
              res_status_next = ST_RANGE;
            end else if (cur.command == CMD_REPLACE) begin
              wr_en   = 1'b1;
              wr_addr = pos_i;
              wr_data = vdat;
            end else if (cur.command == CMD_SWAP) begin
              // Equal indices leave the list as it is
              if (pos_i != oth_i) begin
                rd_addr    = pos_i;
                state_next = S_SWAP_A;
              end
            end else begin
              rd_addr    = pos_i;
              state_next = S_FETCH;
            end
          end
          CMD_SEARCH: begin
            if (cnt != '0) begin
              ptr_next   = '0;
              left_next  = cnt;
              state_next = S_SCAN;
            end
          end
          CMD_CLEAR: begin
            cnt_next = '0;
          end
          default: begin
          end
        endcase
      end

      // Shift entries one per cycle: read a source, write it one slot over next cycle
      S_MOVE: begin
        if (left != '0) begin
          rd_addr       = ptr;
          pipe_vld_next = 1'b1;
          pipe_dst_next = dir_up ? ptr + 1'b1 : ptr - 1'b1;
          ptr_next      = dir_up ? ptr - 1'b1 : ptr + 1'b1;
          left_next     = left - 1'b1;
        end
        if (pipe_vld) begin
          wr_en   = 1'b1;
          wr_addr = pipe_dst;
          wr_data = rd_data;
        end else if (left == '0) begin
          if (dir_up) begin
            wr_en    = 1'b1;
            wr_addr  = place;
            wr_data  = vdat;
            cnt_next = cnt + 1'b1;
          end else begin
            cnt_next = cnt - 1'b1;
          end
          state_next = S_RESP;
        end
      end

      // Walk the entries in order, compare each against the value
      S_SCAN: begin
        if (left != '0) begin
          rd_addr       = ptr;
          pipe_vld_next = 1'b1;
          ptr_next      = ptr + 1'b1;
          left_next     = left - 1'b1;
        end
        if (pipe_vld && eq) begin
          res_found_next = 1'b1;
        end
        if (left == '0 && !pipe_vld) begin
          state_next = S_RESP;
        end
      end

      S_FETCH: begin
        if (cur.command == CMD_READ) begin
          res_read_next = rd64[31:0];
        end else begin
          res_found_next = eq;
        end
        state_next = S_RESP;
      end

      // Swap: hold the first entry, copy the second over it, then write the held one
      S_SWAP_A: begin
        rd_addr    = oth_i;
        tmp_next   = rd_data;
        state_next = S_SWAP_B;
      end

      S_SWAP_B: begin
        wr_en      = 1'b1;
        wr_addr    = pos_i;
        wr_data    = rd_data;
        state_next = S_SWAP_C;
      end

      S_SWAP_C: begin
        wr_en      = 1'b1;
        wr_addr    = oth_i;
        wr_data    = tmp;
        state_next = S_RESP;
      end

      // Load the output register once it is free
      S_RESP: begin
        if (!res_valid || res_ready) begin
          res_item_next.status     = res_status;
          res_item_next.read_value = res_read;
          res_item_next.found      = res_found;
          res_item_next.count      = 5'(cnt);
          res_valid_next           = 1'b1;
          state_next               = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Checks on the sequencer
  `ILE_ASSERT_IMP(a_cnt_bound, 1'b1, cnt <= CNT_W'(CAPACITY), "count above capacity")
  `ILE_ASSERT_NXT(a_accept_decode, cmd_valid && cmd_ready, state == S_DECODE, "no decode after accept")
  `ILE_ASSERT_IMP(a_wr_range, wr_en, 32'(wr_addr) < 32'(CAPACITY), "store write out of range")
  `ILE_ASSERT_IMP(a_full_status, state == S_RESP && res_status == ST_FULL, cnt == CNT_W'(CAPACITY), "full status with room left")
  `ILE_ASSERT_IMP(a_pipe_state, pipe_vld, state == S_MOVE || state == S_SCAN, "pending read outside move or scan")

endmodule
